// ===== rtl/mu8_pkg.sv =====
// Package for the modified UTF-8 validator and decoder.
// Holds the byte-class constants and the types shared by the decoder and top level.
// No dependencies.
`timescale 1ns / 1ps

package mu8_pkg;

    // Byte classes and field masks.
    localparam logic [7:0] ContMask  = 8'hC0;
    localparam logic [7:0] ContTag   = 8'h80;
    localparam logic [7:0] AsciiMax  = 8'h7F;
    localparam logic [7:0] Lead2Max  = 8'hDF;
    localparam logic [7:0] Lead2Bits = 8'h1F;
    localparam logic [7:0] Lead3Bits = 8'h0F;
    localparam logic [7:0] ContBits  = 8'h3F;
    localparam logic [7:0] BadMin    = 8'hF0;
    localparam logic [7:0] Lead3Min  = 8'hE0;

    // Most results one input item can cause.
    localparam int unsigned MaxRes = 3;

    // One result item.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_ok;
        logic        final_result;
        logic        string_valid;
    } t_result;

    // Bytes of an unfinished sequence and the string status.
    typedef struct packed {
        logic [1:0][7:0] bytes;
        logic [1:0]      count;
        logic            valid_so_far;
    } t_pend;

endpackage

// ===== rtl/mu8_if.sv =====
// Valid/ready channel interfaces for the input bytes and the result items.
// Depends on nothing.
`timescale 1ns / 1ps

interface mu8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface mu8_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        unit_ok;
    logic        final_result;
    logic        string_valid;

    modport source (output valid, output code_unit, output unit_ok,
                    output final_result, output string_valid, input ready);
    modport sink   (input valid, input code_unit, input unit_ok,
                    input final_result, input string_valid, output ready);
endinterface

// ===== rtl/mu8_decode.sv =====
// Combinational step of the decoder: held bytes plus one new byte in, results out.
// Depends on mu8_pkg.
`timescale 1ns / 1ps

module mu8_decode (
    input  mu8_pkg::t_pend                       i_pend,
    input  logic [7:0]                           i_data_byte,
    input  logic                                 i_end_of_string,
    output mu8_pkg::t_result [mu8_pkg::MaxRes-1:0] o_res,
    output logic [1:0]                           o_res_count,
    output mu8_pkg::t_pend                       o_pend
);

    function automatic logic is_cont(input logic [7:0] b);
        return (b & mu8_pkg::ContMask) == mu8_pkg::ContTag;
    endfunction

    logic [3:0][7:0] bytes;
    logic [1:0]      n;
    logic [1:0]      p;
    logic [1:0]      avail;
    logic [1:0]      r;
    logic [1:0]      adv;
    logic            stop;
    logic            vsf;
    logic            emit;
    logic            ok;
    logic [15:0]     unit;
    logic [7:0]      b;
    logic [7:0]      c1;
    logic [7:0]      c2;
    logic            enough;

    always_comb begin
        // Line up the held bytes in front of the new byte.
        bytes = '0;
        unique case (i_pend.count)
            2'd0: begin
                bytes[0] = i_data_byte;
                n        = 2'd1;
            end
            2'd1: begin
                bytes[0] = i_pend.bytes[0];
                bytes[1] = i_data_byte;
                n        = 2'd2;
            end
            default: begin
                bytes[0] = i_pend.bytes[0];
                bytes[1] = i_pend.bytes[1];
                bytes[2] = i_data_byte;
                n        = 2'd3;
            end
        endcase

        p      = '0;
        r      = '0;
        stop   = 1'b0;
        vsf    = i_pend.valid_so_far;
        o_res  = '0;
        avail  = '0;
        adv    = '0;
        emit   = 1'b0;
        ok     = 1'b0;
        unit   = '0;
        b      = '0;
        c1     = '0;
        c2     = '0;
        enough = 1'b0;

        // At most one result per byte, so three passes resolve the buffer.
        for (int k = 0; k < mu8_pkg::MaxRes; k++) begin
            emit = 1'b0;
            adv  = 2'd1;
            if (!stop && (p < n)) begin
                b     = bytes[p];
                c1    = bytes[p + 2'd1];
                c2    = bytes[p + 2'd2];
                avail = n - p;
                emit  = 1'b1;
                ok    = 1'b0;
                unit  = {8'h00, b};
                if ((b == 8'h00) || (b >= mu8_pkg::BadMin) || is_cont(b)) begin
                    ok = 1'b0;
                end else if (b <= mu8_pkg::AsciiMax) begin
                    ok = 1'b1;
                end else begin
                    enough = (b < mu8_pkg::Lead3Min) ? (avail >= 2'd2) : (avail == 2'd3);
                    if (!enough) begin
                        // A lead waits for its continuations unless the string ends.
                        if (!i_end_of_string) begin
                            stop = 1'b1;
                            emit = 1'b0;
                        end
                    end else if (b <= mu8_pkg::Lead2Max) begin
                        if (is_cont(c1)) begin
                            ok   = 1'b1;
                            unit = {5'd0, b[4:0] & mu8_pkg::Lead2Bits[4:0],
                                    c1[5:0] & mu8_pkg::ContBits[5:0]};
                            adv  = 2'd2;
                        end
                    end else begin
                        if (is_cont(c1) && is_cont(c2)) begin
                            ok   = 1'b1;
                            unit = {b[3:0] & mu8_pkg::Lead3Bits[3:0],
                                    c1[5:0] & mu8_pkg::ContBits[5:0],
                                    c2[5:0] & mu8_pkg::ContBits[5:0]};
                            adv  = 2'd3;
                        end
                    end
                end
                if (emit) begin
                    o_res[r].code_unit = unit;
                    o_res[r].unit_ok   = ok;
                    r                  = r + 2'd1;
                    p                  = p + adv;
                    if (!ok) begin
                        vsf = 1'b0;
                    end
                end
            end
        end

        // The last result of a string carries its overall status.
        o_pend = '0;
        if (i_end_of_string) begin
            if (r != 2'd0) begin
                o_res[r - 2'd1].final_result = 1'b1;
                o_res[r - 2'd1].string_valid = vsf;
            end
            o_pend.count        = 2'd0;
            o_pend.valid_so_far = 1'b1;
        end else begin
            o_pend.bytes[0]     = bytes[p];
            o_pend.bytes[1]     = bytes[p + 2'd1];
            o_pend.count        = n - p;
            o_pend.valid_so_far = vsf;
        end
        o_res_count = r;
    end

endmodule

// ===== rtl/modified_utf8_validate_decode.sv =====
// Top level of the modified UTF-8 validator and decoder.
// Depends on mu8_pkg, mu8_byte_if, mu8_unit_if and mu8_decode.
`timescale 1ns / 1ps

//  channel   direction  payload
//  i_byte    in         data_byte[7:0], end_of_string
//  o_unit    out        code_unit[15:0], unit_ok, final_result, string_valid
//
// A byte is decoded in the cycle it is accepted; its results sit in a three-entry
// result register and leave one per cycle while the receiver is ready. A byte with one
// result lets the next byte in the next cycle if that result is taken; a byte that
// resolves several held bytes stalls input until all but its last result are taken.
// Reset clears the held byte and result counts; a stalled result holds until taken.

module modified_utf8_validate_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mu8_byte_if.sink          i_byte,
    mu8_unit_if.source        o_unit
);

    mu8_pkg::t_pend                          r_pend;
    mu8_pkg::t_pend                          n_pend;
    mu8_pkg::t_result [mu8_pkg::MaxRes-1:0]  r_res;
    mu8_pkg::t_result [mu8_pkg::MaxRes-1:0]  n_res;
    logic [1:0]                              r_cnt;
    logic [1:0]                              n_cnt;
    logic                                    accept;
    logic                                    pop;

    mu8_decode u_decode (
        .i_pend          (r_pend),
        .i_data_byte     (i_byte.data_byte),
        .i_end_of_string (i_byte.end_of_string),
        .o_res           (n_res),
        .o_res_count     (n_cnt),
        .o_pend          (n_pend)
    );

    // Take a byte when the result register is empty or empties in this cycle.
    assign pop          = o_unit.valid && o_unit.ready;
    assign i_byte.ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_unit.ready);
    assign accept       = i_byte.valid && i_byte.ready;

    assign o_unit.valid        = (r_cnt != 2'd0);
    assign o_unit.code_unit    = r_res[0].code_unit;
    assign o_unit.unit_ok      = r_res[0].unit_ok;
    assign o_unit.final_result = r_res[0].final_result;
    assign o_unit.string_valid = r_res[0].string_valid;

    // Decoder state and result count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend.count        <= 2'd0;
            r_pend.valid_so_far <= 1'b1;
            r_cnt               <= 2'd0;
        end else if (accept) begin
            r_pend.bytes        <= n_pend.bytes;
            r_pend.count        <= n_pend.count;
            r_pend.valid_so_far <= n_pend.valid_so_far;
            r_cnt               <= n_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Result entries load on accept and shift toward the head on each take.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res              <= n_res;
        end else if (pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for modified_utf8_validate_decode.
// Drives bytes of encoded strings and compares each decoded code unit against a local decoder.
// Depends on mu8_pkg, mu8_byte_if, mu8_unit_if and the top level of the block.
`timescale 1ns / 1ps

module tb_top;

    // Run limits.
    localparam int RandItems    = 200;
    localparam int HoldCycles   = 60;
    localparam int SettleCycles = 12;
    localparam int IdleLimit    = 2000;
    localparam int ReportMax    = 10;

    // One row of the directed table: a byte, its end flag and an optional fixed result.
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             eos;
        logic             fixed;
        mu8_pkg::t_result unit;
    } t_row;

    localparam mu8_pkg::t_result NoUnit = '0;
    localparam int DirRows = 25;
    localparam t_row DirTable [DirRows] = '{
        // Single bytes right after reset, the byte extremes and forbidden bytes.
        '{8'h41, 1'b1, 1'b1, '{16'h0041, 1'b1, 1'b1, 1'b1}},
        '{8'h00, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{16'h00FF, 1'b0, 1'b1, 1'b0}},
        '{8'hF0, 1'b1, 1'b1, '{16'h00F0, 1'b0, 1'b1, 1'b0}},
        // Stray continuations in lead position.
        '{8'h80, 1'b1, 1'b1, '{16'h0080, 1'b0, 1'b1, 1'b0}},
        '{8'hBF, 1'b1, 1'b1, '{16'h00BF, 1'b0, 1'b1, 1'b0}},
        // Lowest and highest one-byte characters in one string.
        '{8'h01, 1'b0, 1'b1, '{16'h0001, 1'b1, 1'b0, 1'b0}},
        '{8'h7F, 1'b1, 1'b1, '{16'h007F, 1'b1, 1'b1, 1'b1}},
        // Overlong zero, then the largest two- and three-byte forms.
        '{8'hC0, 1'b0, 1'b0, NoUnit},
        '{8'h80, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b1, 1'b1}},
        '{8'hDF, 1'b0, 1'b0, NoUnit},
        '{8'hBF, 1'b1, 1'b0, NoUnit},
        '{8'hEF, 1'b0, 1'b0, NoUnit},
        '{8'hBF, 1'b0, 1'b0, NoUnit},
        '{8'hBF, 1'b1, 1'b0, NoUnit},
        // Bad continuation after a three-byte lead: lead and stray byte rejected.
        '{8'hE0, 1'b0, 1'b0, NoUnit},
        '{8'h80, 1'b0, 1'b0, NoUnit},
        '{8'h41, 1'b1, 1'b0, NoUnit},
        // Bad continuation after a two-byte lead.
        '{8'hC5, 1'b0, 1'b0, NoUnit},
        '{8'h20, 1'b1, 1'b0, NoUnit},
        // Sequences cut by the end of the string.
        '{8'hE1, 1'b0, 1'b0, NoUnit},
        '{8'h81, 1'b1, 1'b0, NoUnit},
        '{8'hC3, 1'b1, 1'b0, NoUnit},
        '{8'hE2, 1'b0, 1'b0, NoUnit},
        '{8'hC8, 1'b1, 1'b0, NoUnit}
    };

    logic i_clk;
    logic i_rst_n;

    mu8_byte_if bbus();
    mu8_unit_if ubus();

    modified_utf8_validate_decode uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (bbus),
        .o_unit  (ubus)
    );

    // Decoder state kept alongside the block.
    logic [7:0]        held_bytes [2];
    int                held_cnt;
    logic              str_ok;
    mu8_pkg::t_result  fresh_units[$];
    mu8_pkg::t_result  unit_q[$];
    logic [7:0]        str_bytes[$];

    int          mism_cnt;
    int          idle_cnt;
    int          burst_left;
    logic        hold_req;
    logic        drain_req;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic is_cont_byte(input logic [7:0] b);
        return (b & mu8_pkg::ContMask) == mu8_pkg::ContTag;
    endfunction

    // Append one byte to the string being built.
    function automatic void put_byte(input int unsigned v);
        str_bytes = {str_bytes, v[7:0]};
    endfunction

    function automatic void add_unit(input logic [15:0] cu, input logic ok);
        mu8_pkg::t_result u;
        u.code_unit    = cu;
        u.unit_ok      = ok;
        u.final_result = 1'b0;
        u.string_valid = 1'b0;
        fresh_units = {fresh_units, u};
        if (!ok) begin
            str_ok = 1'b0;
        end
    endfunction

    // Decode one accepted byte together with the held ones into fresh_units.
    function automatic void decode_byte(input logic [7:0] b, input logic eos);
        logic [7:0]       win [3];
        logic [7:0]       lead;
        mu8_pkg::t_result last;
        int               n;
        int               p;
        int               need;
        int               k;
        n = 0;
        p = 0;
        fresh_units.delete();
        for (k = 0; k < held_cnt; k++) begin
            win[n] = held_bytes[k];
            n++;
        end
        win[n] = b;
        n++;

        while (p < n) begin
            lead = win[p];
            if (lead == 8'h00 || lead >= mu8_pkg::BadMin || is_cont_byte(lead)) begin
                add_unit({8'h00, lead}, 1'b0);
                p++;
            end else if (lead <= mu8_pkg::AsciiMax) begin
                add_unit({8'h00, lead}, 1'b1);
                p++;
            end else begin
                need = (lead <= mu8_pkg::Lead2Max) ? 2 : 3;
                if (n - p < need) begin
                    // Wait for more continuations unless the string ends here.
                    if (!eos) break;
                    add_unit({8'h00, lead}, 1'b0);
                    p++;
                end else if (need == 2) begin
                    if (is_cont_byte(win[p+1])) begin
                        add_unit({5'b0, lead[4:0], win[p+1][5:0]}, 1'b1);
                        p += 2;
                    end else begin
                        add_unit({8'h00, lead}, 1'b0);
                        p++;
                    end
                end else begin
                    if (is_cont_byte(win[p+1]) && is_cont_byte(win[p+2])) begin
                        add_unit({lead[3:0], win[p+1][5:0], win[p+2][5:0]}, 1'b1);
                        p += 3;
                    end else begin
                        add_unit({8'h00, lead}, 1'b0);
                        p++;
                    end
                end
            end
        end

        if (eos) begin
            // The last unit of the string carries the whole-string verdict.
            last = fresh_units.pop_back();
            last.final_result = 1'b1;
            last.string_valid = str_ok;
            fresh_units = {fresh_units, last};
            held_cnt = 0;
            str_ok   = 1'b1;
        end else begin
            held_cnt = 0;
            while (p < n && held_cnt < 2) begin
                held_bytes[held_cnt] = win[p];
                held_cnt++;
                p++;
            end
        end
    endfunction

    // Offer one byte, record its expected units once taken, then idle as the burst says.
    task automatic send_byte(input logic [7:0] b, input logic eos, input logic fixed,
                             input mu8_pkg::t_result unit);
        int gap;
        bbus.valid         <= 1'b1;
        bbus.data_byte     <= b;
        bbus.end_of_string <= eos;
        do @(posedge i_clk); while (!bbus.ready);

        decode_byte(b, eos);
        if (fixed) begin
            unit_q = {unit_q, unit};
        end else begin
            unit_q = {unit_q, fresh_units};
        end

        if (drain_req) begin
            // Hold the input until every expected unit has come out.
            drain_req  = 1'b0;
            bbus.valid <= 1'b0;
            while (unit_q.size() != 0) @(posedge i_clk);
        end else begin
            burst_left--;
            if (burst_left <= 0) begin
                gap = $urandom_range(1, 6);
                bbus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
            end
        end
    endtask

    task automatic report_unit(input logic have_want, input mu8_pkg::t_result want,
                               input mu8_pkg::t_result got);
        mism_cnt++;
        if (mism_cnt <= ReportMax) begin
            if (have_want) begin
                $display("%0t: mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                         $realtime, want.code_unit, want.unit_ok, want.final_result,
                         want.string_valid, got.code_unit, got.unit_ok,
                         got.final_result, got.string_valid);
            end else begin
                $display("%0t: unexpected unit %h ok=%b fin=%b sv=%b", $realtime,
                         got.code_unit, got.unit_ok, got.final_result, got.string_valid);
            end
        end
    endtask

    // Compare each unit taken from the block with the oldest expectation.
    always @(posedge i_clk) begin : unit_check
        mu8_pkg::t_result got;
        mu8_pkg::t_result want;
        if (!i_rst_n) begin
            mism_cnt = 0;
        end else if (ubus.valid && ubus.ready) begin
            got = '{ubus.code_unit, ubus.unit_ok, ubus.final_result, ubus.string_valid};
            if (unit_q.size() == 0) begin
                report_unit(1'b0, NoUnit, got);
            end else begin
                want = unit_q.pop_front();
                if (got !== want) begin
                    report_unit(1'b1, want, got);
                end
            end
        end
    end

    // End the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cnt <= 0;
        end else begin
            if ((bbus.valid && bbus.ready) || (ubus.valid && ubus.ready)) begin
                idle_cnt <= 0;
            end else if (idle_cnt >= IdleLimit) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cnt <= idle_cnt + 1;
            end
        end
    end

    // Receiver: segments of random stall density, plus one long hold-off on request.
    initial begin : unit_sink
        int   seg_len;
        int   stall_pct;
        int   hold_cnt;
        logic hold_taken;
        seg_len    = 0;
        stall_pct  = 0;
        hold_cnt   = 0;
        hold_taken = 1'b0;
        ubus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_cnt   = HoldCycles;
            end
            if (seg_len == 0) begin
                seg_len = $urandom_range(4, 40);
                case ($urandom_range(3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_len--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                ubus.ready <= 1'b0;
            end else begin
                ubus.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Main stimulus: reset, directed table, then random strings.
    initial begin : byte_source
        logic       bad_str;
        int         n_chars;
        int         rand_cnt;
        int         c;
        int         j;
        logic       hold_done;
        logic       drain_done;

        i_rst_n            = 1'b0;
        bbus.valid         = 1'b0;
        bbus.data_byte     = 8'h00;
        bbus.end_of_string = 1'b0;
        hold_req           = 1'b0;
        drain_req          = 1'b0;
        held_cnt           = 0;
        str_ok             = 1'b1;
        burst_left         = $urandom_range(1, 8);
        rand_cnt           = 0;
        hold_done          = 1'b0;
        drain_done         = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (j = 0; j < DirRows; j++) begin
            send_byte(DirTable[j].data_byte, DirTable[j].eos, DirTable[j].fixed,
                      DirTable[j].unit);
        end

        // Random strings: most well formed, some with broken or cut sequences.
        while (rand_cnt < RandItems) begin
            str_bytes.delete();
            bad_str = ($urandom_range(99) < 30);
            n_chars = $urandom_range(1, 6);
            for (c = 0; c < n_chars; c++) begin
                if (bad_str && $urandom_range(2) == 0) begin
                    case ($urandom_range(4))
                        0: put_byte($urandom_range(0, 255));
                        1: begin
                            put_byte($urandom_range(8'hC0, 8'hDF));
                            put_byte($urandom_range(8'h01, 8'h7F));
                        end
                        2: begin
                            put_byte($urandom_range(8'hE0, 8'hEF));
                            put_byte($urandom_range(8'h80, 8'hBF));
                            put_byte($urandom_range(0, 255));
                        end
                        3: put_byte($urandom_range(8'h80, 8'hBF));
                        default: put_byte($urandom_range(8'hC0, 8'hEF));
                    endcase
                end else begin
                    case ($urandom_range(9))
                        0, 1, 2, 3: put_byte($urandom_range(8'h01, 8'h7F));
                        4, 5, 6: begin
                            put_byte($urandom_range(8'hC0, 8'hDF));
                            put_byte($urandom_range(8'h80, 8'hBF));
                        end
                        default: begin
                            put_byte($urandom_range(8'hE0, 8'hEF));
                            put_byte($urandom_range(8'h80, 8'hBF));
                            put_byte($urandom_range(8'h80, 8'hBF));
                        end
                    endcase
                end
            end

            foreach (str_bytes[k]) begin
                // Long receiver hold-off while the input keeps offering bytes.
                if (!hold_done && rand_cnt >= 80) begin
                    hold_done  = 1'b1;
                    hold_req   = 1'b1;
                    burst_left = HoldCycles;
                end
                // Once, let the block drain completely before going on.
                if (!drain_done && rand_cnt >= 150) begin
                    drain_done = 1'b1;
                    drain_req  = 1'b1;
                end
                send_byte(str_bytes[k], (k == str_bytes.size() - 1), 1'b0, NoUnit);
                rand_cnt++;
            end
        end

        // Drop valid in the cycle of the last accept so no byte is offered twice.
        bbus.valid <= 1'b0;
        while (unit_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);

        if (mism_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
